/* rtl/core/one_wire_rom_search_unit_defines.svh */
// Assertion macros for the 1-Wire ROM search unit.
`ifndef ONE_WIRE_ROM_SEARCH_UNIT_DEFINES_SVH
`define ONE_WIRE_ROM_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OWRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OWRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/owrs_pkg.sv */
// Types and constants of the 1-Wire ROM search unit.
package owrs_pkg;

    localparam int ROM_BITS = 64;
    localparam int POS_W    = 7;
    localparam int LFD_W    = 4;

    localparam logic [POS_W-1:0] POS_FIRST     = 7'd1;
    localparam logic [POS_W-1:0] POS_LAST      = 7'd64;
    localparam logic [POS_W-1:0] POS_FAMILY_LIM = 7'd9;

    localparam logic [2:0] OP_START_FIRST = 3'd0;
    localparam logic [2:0] OP_START_NEXT  = 3'd1;
    localparam logic [2:0] OP_PRESENCE    = 3'd2;
    localparam logic [2:0] OP_BIT_PAIR    = 3'd3;
    localparam logic [2:0] OP_TARGET_FAM  = 3'd4;
    localparam logic [2:0] OP_SKIP_FAM    = 3'd5;

    localparam logic [2:0] ACT_ACK        = 3'd0;
    localparam logic [2:0] ACT_RESET      = 3'd1;
    localparam logic [2:0] ACT_SEARCH_CMD = 3'd2;
    localparam logic [2:0] ACT_WRITE      = 3'd3;
    localparam logic [2:0] ACT_DONE       = 3'd4;

    typedef struct packed {
        logic [2:0]          action;
        logic                direction_bit;
        logic                found;
        logic [ROM_BITS-1:0] rom_number;
        logic                last_device;
        logic                last_of_run;
    } result_t;

endpackage

/* rtl/core/one_wire_rom_search_unit.sv */
// Top level of the 1-Wire ROM search unit.
// Results are registered onto m_ in the cycle after their item is accepted;
// one item per cycle while m_ready is high. The item completing bit 64 gives
// two results and holds s_ready low while both wait. A two-entry result buffer
// decouples the channels. Reset (aresetn low, synchronous) clears the ROM ID,
// discrepancies and flag, sets the bit position to one and the phase to idle.
module one_wire_rom_search_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic        s_presence_ok,
    input  logic        s_id_bit,
    input  logic        s_complement_bit,
    input  logic [7:0]  s_family_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic        m_direction_bit,
    output logic        m_found,
    output logic [63:0] m_rom_number,
    output logic        m_last_device,
    output logic        m_last_of_run
);

    `include "one_wire_rom_search_unit_defines.svh"

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_PRESENCE,
        PH_SEARCHING
    } phase_t;

    phase_t                                 phase_reg, phase_next;
    logic [owrs_pkg::ROM_BITS-1:0]          rom_reg, rom_next;
    logic [owrs_pkg::POS_W-1:0]             ld_reg, ld_next;
    logic [owrs_pkg::LFD_W-1:0]             lfd_reg, lfd_next;
    logic                                   ldf_reg, ldf_next;
    logic [owrs_pkg::POS_W-1:0]             bp_reg, bp_next;
    logic [owrs_pkg::POS_W-1:0]             lzp_reg, lzp_next;

    owrs_pkg::result_t buf0_reg, buf1_reg;
    owrs_pkg::result_t res0, res1;
    logic [1:0]        count_reg;

    logic       accept, pop, two_res, dir, found, bp_ok;
    logic [2:0] act0;
    logic [5:0] idx;

    assign pop     = (count_reg != 2'd0) && m_ready;
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign accept  = s_valid && s_ready;

    assign idx   = bp_reg[5:0] - 6'd1;
    assign bp_ok = (bp_reg >= owrs_pkg::POS_FIRST) && (bp_reg <= owrs_pkg::POS_LAST);

    always_comb begin
        phase_next = phase_reg;
        rom_next   = rom_reg;
        ld_next    = ld_reg;
        lfd_next   = lfd_reg;
        ldf_next   = ldf_reg;
        bp_next    = bp_reg;
        lzp_next   = lzp_reg;
        act0       = owrs_pkg::ACT_ACK;
        dir        = 1'b0;
        found      = 1'b0;
        two_res    = 1'b0;
        unique case (s_operation) inside
            owrs_pkg::OP_START_FIRST, owrs_pkg::OP_START_NEXT: begin
                bp_next  = owrs_pkg::POS_FIRST;
                lzp_next = '0;
                if (s_operation == owrs_pkg::OP_START_NEXT && ldf_reg) begin
                    ld_next    = '0;
                    lfd_next   = '0;
                    ldf_next   = 1'b0;
                    phase_next = PH_IDLE;
                    act0       = owrs_pkg::ACT_DONE;
                end else begin
                    if (s_operation == owrs_pkg::OP_START_FIRST) begin
                        ld_next  = '0;
                        lfd_next = '0;
                        ldf_next = 1'b0;
                    end
                    phase_next = PH_WAIT_PRESENCE;
                    act0       = owrs_pkg::ACT_RESET;
                end
            end
            owrs_pkg::OP_PRESENCE: begin
                if (phase_reg == PH_WAIT_PRESENCE) begin
                    if (!s_presence_ok) begin
                        ld_next    = '0;
                        lfd_next   = '0;
                        ldf_next   = 1'b0;
                        phase_next = PH_IDLE;
                        act0       = owrs_pkg::ACT_DONE;
                    end else begin
                        phase_next = PH_SEARCHING;
                        act0       = owrs_pkg::ACT_SEARCH_CMD;
                    end
                end
            end
            owrs_pkg::OP_BIT_PAIR: begin
                if (phase_reg == PH_SEARCHING && bp_ok) begin
                    if (s_id_bit && s_complement_bit) begin
                        ld_next    = '0;
                        lfd_next   = '0;
                        ldf_next   = 1'b0;
                        phase_next = PH_IDLE;
                        act0       = owrs_pkg::ACT_DONE;
                    end else begin
                        if (s_id_bit != s_complement_bit) begin
                            dir = s_id_bit;
                        end else begin
                            if (bp_reg < ld_reg) begin
                                dir = rom_reg[idx];
                            end else begin
                                dir = (bp_reg == ld_reg);
                            end
                            if (!dir) begin
                                lzp_next = bp_reg;
                                if (bp_reg < owrs_pkg::POS_FAMILY_LIM) begin
                                    lfd_next = bp_reg[owrs_pkg::LFD_W-1:0];
                                end
                            end
                        end
                        rom_next[idx] = dir;
                        bp_next       = bp_reg + 7'd1;
                        act0          = owrs_pkg::ACT_WRITE;
                        if (bp_reg == owrs_pkg::POS_LAST) begin
                            two_res = 1'b1;
                            ld_next = lzp_next;
                            if (lzp_next == '0) begin
                                ldf_next = 1'b1;
                            end
                            found = 1'b1;
                            if (rom_next[7:0] == 8'd0) begin
                                ld_next  = '0;
                                lfd_next = '0;
                                ldf_next = 1'b0;
                                found    = 1'b0;
                            end
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            owrs_pkg::OP_TARGET_FAM: begin
                if (phase_reg == PH_IDLE) begin
                    rom_next = {{(owrs_pkg::ROM_BITS-8){1'b0}}, s_family_code};
                    ld_next  = owrs_pkg::POS_LAST;
                    lfd_next = '0;
                    ldf_next = 1'b0;
                end
            end
            owrs_pkg::OP_SKIP_FAM: begin
                if (phase_reg == PH_IDLE) begin
                    ld_next  = {{(owrs_pkg::POS_W-owrs_pkg::LFD_W){1'b0}}, lfd_reg};
                    lfd_next = '0;
                    if (lfd_reg == '0) begin
                        ldf_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        res0.action        = act0;
        res0.direction_bit = dir;
        res0.found         = 1'b0;
        res0.rom_number    = rom_next;
        res0.last_device   = two_res ? ldf_reg : ldf_next;
        res0.last_of_run   = !two_res;

        res1.action        = owrs_pkg::ACT_DONE;
        res1.direction_bit = 1'b0;
        res1.found         = found;
        res1.rom_number    = rom_next;
        res1.last_device   = ldf_next;
        res1.last_of_run   = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            rom_reg   <= '0;
            ld_reg    <= '0;
            lfd_reg   <= '0;
            ldf_reg   <= 1'b0;
            bp_reg    <= owrs_pkg::POS_FIRST;
            lzp_reg   <= '0;
            count_reg <= 2'd0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                rom_reg   <= rom_next;
                ld_reg    <= ld_next;
                lfd_reg   <= lfd_next;
                ldf_reg   <= ldf_next;
                bp_reg    <= bp_next;
                lzp_reg   <= lzp_next;
                count_reg <= two_res ? 2'd2 : 2'd1;
            end else if (pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf0_reg <= res0;
            buf1_reg <= res1;
        end else if (pop) begin
            buf0_reg <= buf1_reg;
        end
    end

    assign m_valid         = (count_reg != 2'd0);
    assign m_action        = buf0_reg.action;
    assign m_direction_bit = buf0_reg.direction_bit;
    assign m_found         = buf0_reg.found;
    assign m_rom_number    = buf0_reg.rom_number;
    assign m_last_device   = buf0_reg.last_device;
    assign m_last_of_run   = buf0_reg.last_of_run;

    `OWRS_ASSERT_IMP(a_count_max, 1'b1, count_reg <= 2'd2, "result buffer overfilled")
    `OWRS_ASSERT_NXT(a_item_gives_result, accept, count_reg != 2'd0, "item produced no result")
    `OWRS_ASSERT_IMP(a_pair_order, count_reg == 2'd2,
        !buf0_reg.last_of_run && buf0_reg.action == owrs_pkg::ACT_WRITE &&
        buf1_reg.action == owrs_pkg::ACT_DONE, "bad final write/done pair")
    `OWRS_ASSERT_IMP(a_search_pos, phase_reg == PH_SEARCHING, bp_ok, "bit position out of range")

endmodule

/* sim/one_wire_rom_search_unit_test.sv */
// Self-checking testbench for the 1-Wire ROM search unit with a simulated device bus.
`timescale 1ns / 100ps

module one_wire_rom_search_unit_test;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam int RANDOM_ITEMS = 1050;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_DEVICES  = 4;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT_PRES, PH_SEARCH} engine_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = OP_UNUSED_7;
    logic        s_presence_ok = 1'b0;
    logic        s_id_bit = 1'b0;
    logic        s_complement_bit = 1'b0;
    logic [7:0]  s_family_code = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_action;
    logic        m_direction_bit;
    logic        m_found;
    logic [63:0] m_rom_number;
    logic        m_last_device;
    logic        m_last_of_run;

    one_wire_rom_search_unit dut (.*);

    // search engine state mirror
    logic [owrs_pkg::ROM_BITS-1:0] rom_image;
    logic [owrs_pkg::POS_W-1:0]    disc_pos;
    logic [owrs_pkg::LFD_W-1:0]    family_disc_pos;
    logic                          at_last_device;
    logic [owrs_pkg::POS_W-1:0]    next_bit;
    logic [owrs_pkg::POS_W-1:0]    zero_taken;
    engine_phase_t                 engine_phase;
    logic                          search_dir;
    logic                          search_found;

    owrs_pkg::result_t owed_actions[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    bit      steady = 1'b0;

    // simulated bus
    logic [63:0] device_rom[MAX_DEVICES];
    int          device_total;

    always #5 aclk = ~aclk;

    function automatic void owe_action(logic [2:0] act, logic dir, logic fnd, logic last);
        owrs_pkg::result_t r;
        r.action        = act;
        r.direction_bit = dir;
        r.found         = fnd;
        r.rom_number    = rom_image;
        r.last_device   = at_last_device;
        r.last_of_run   = last;
        owed_actions.push_back(r);
    endfunction

    function automatic void clear_discrepancies();
        disc_pos        = '0;
        family_disc_pos = '0;
        at_last_device  = 1'b0;
    endfunction

    function automatic void search_engine_step(logic [2:0] op, logic pres, logic idb,
                                               logic cmpb, logic [7:0] fam);
        int   idx;
        logic dir;
        case (op) inside
            owrs_pkg::OP_START_FIRST, owrs_pkg::OP_START_NEXT: begin
                search_found = 1'b0;
                if (op == owrs_pkg::OP_START_FIRST)
                    clear_discrepancies();
                next_bit   = owrs_pkg::POS_FIRST;
                zero_taken = '0;
                if (at_last_device) begin
                    clear_discrepancies();
                    engine_phase = PH_IDLE;
                    owe_action(owrs_pkg::ACT_DONE, 1'b0, 1'b0, 1'b1);
                end else begin
                    engine_phase = PH_WAIT_PRES;
                    owe_action(owrs_pkg::ACT_RESET, 1'b0, 1'b0, 1'b1);
                end
            end
            owrs_pkg::OP_PRESENCE: begin
                if (engine_phase != PH_WAIT_PRES) begin
                    owe_action(owrs_pkg::ACT_ACK, 1'b0, 1'b0, 1'b1);
                end else if (!pres) begin
                    clear_discrepancies();
                    engine_phase = PH_IDLE;
                    owe_action(owrs_pkg::ACT_DONE, 1'b0, 1'b0, 1'b1);
                end else begin
                    engine_phase = PH_SEARCH;
                    owe_action(owrs_pkg::ACT_SEARCH_CMD, 1'b0, 1'b0, 1'b1);
                end
            end
            owrs_pkg::OP_BIT_PAIR: begin
                if (engine_phase != PH_SEARCH || next_bit < owrs_pkg::POS_FIRST ||
                    next_bit > owrs_pkg::POS_LAST) begin
                    owe_action(owrs_pkg::ACT_ACK, 1'b0, 1'b0, 1'b1);
                end else if (idb && cmpb) begin
                    clear_discrepancies();
                    engine_phase = PH_IDLE;
                    owe_action(owrs_pkg::ACT_DONE, 1'b0, 1'b0, 1'b1);
                end else begin
                    idx = int'(next_bit) - 1;
                    if (idb != cmpb) begin
                        dir = idb;
                    end else begin
                        if (next_bit < disc_pos)
                            dir = rom_image[idx];
                        else
                            dir = (next_bit == disc_pos);
                        if (!dir) begin
                            zero_taken = next_bit;
                            if (zero_taken < owrs_pkg::POS_FAMILY_LIM)
                                family_disc_pos = zero_taken[owrs_pkg::LFD_W-1:0];
                        end
                    end
                    rom_image[idx] = dir;
                    search_dir = dir;
                    next_bit = next_bit + 1'b1;
                    if (next_bit <= owrs_pkg::POS_LAST) begin
                        owe_action(owrs_pkg::ACT_WRITE, dir, 1'b0, 1'b1);
                    end else begin
                        owe_action(owrs_pkg::ACT_WRITE, dir, 1'b0, 1'b0);
                        disc_pos = zero_taken;
                        if (disc_pos == '0)
                            at_last_device = 1'b1;
                        search_found = 1'b1;
                        if (rom_image[7:0] == 8'd0) begin
                            clear_discrepancies();
                            search_found = 1'b0;
                        end
                        engine_phase = PH_IDLE;
                        owe_action(owrs_pkg::ACT_DONE, 1'b0, search_found, 1'b1);
                    end
                end
            end
            owrs_pkg::OP_TARGET_FAM: begin
                if (engine_phase == PH_IDLE) begin
                    rom_image       = {56'd0, fam};
                    disc_pos        = owrs_pkg::POS_LAST;
                    family_disc_pos = '0;
                    at_last_device  = 1'b0;
                end
                owe_action(owrs_pkg::ACT_ACK, 1'b0, 1'b0, 1'b1);
            end
            owrs_pkg::OP_SKIP_FAM: begin
                if (engine_phase == PH_IDLE) begin
                    disc_pos        = {{(owrs_pkg::POS_W-owrs_pkg::LFD_W){1'b0}},
                                       family_disc_pos};
                    family_disc_pos = '0;
                    if (disc_pos == '0)
                        at_last_device = 1'b1;
                end
                owe_action(owrs_pkg::ACT_ACK, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                owe_action(owrs_pkg::ACT_ACK, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // sender: call at a rising edge, returns at the edge where the item is taken
    task automatic send_item(logic [2:0] op, logic pres, logic idb, logic cmpb,
                             logic [7:0] fam);
        while (!steady && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_presence_ok    <= pres;
        s_id_bit         <= idb;
        s_complement_bit <= cmpb;
        s_family_code    <= fam;
        do
            @(posedge aclk);
        while (!s_ready);
        search_engine_step(op, pres, idb, cmpb, fam);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(3'($urandom_range(7)), 1'($urandom), 1'($urandom), 1'($urandom),
                  8'($urandom));
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        owrs_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_actions.size() == 0) begin
                report_mismatch("unexpected result action", 64'(m_action), 64'd0);
            end else begin
                want = owed_actions.pop_front();
                if (m_action !== want.action)
                    report_mismatch("action", 64'(m_action), 64'(want.action));
                if (m_direction_bit !== want.direction_bit)
                    report_mismatch("direction_bit", 64'(m_direction_bit),
                                    64'(want.direction_bit));
                if (m_found !== want.found)
                    report_mismatch("found", 64'(m_found), 64'(want.found));
                if (m_rom_number !== want.rom_number)
                    report_mismatch("rom_number", m_rom_number, want.rom_number);
                if (m_last_device !== want.last_device)
                    report_mismatch("last_device", 64'(m_last_device), 64'(want.last_device));
                if (m_last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 64'(m_last_of_run), 64'(want.last_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one search pass against the simulated bus; corrupt breaks it at a random bit
    task automatic run_search(logic [2:0] start_op, bit corrupt);
        int               cut;
        logic             rd_id;
        logic             rd_cmp;
        logic [MAX_DEVICES-1:0] responding;
        send_item(start_op, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        if (engine_phase != PH_WAIT_PRES)
            return;
        send_item(owrs_pkg::OP_PRESENCE, device_total != 0, 1'($urandom), 1'($urandom),
                  8'($urandom));
        if (engine_phase != PH_SEARCH)
            return;
        responding = '0;
        for (int i = 0; i < device_total; i++)
            responding[i] = 1'b1;
        cut = corrupt ? $urandom_range(owrs_pkg::ROM_BITS - 1) : -1;
        for (int b = 0; b < owrs_pkg::ROM_BITS; b++) begin
            if (b == cut) begin
                if ($urandom_range(1))
                    send_item(owrs_pkg::OP_BIT_PAIR, 1'($urandom), 1'b1, 1'b1, 8'($urandom));
                else
                    send_noise();
                return;
            end
            rd_id  = 1'b1;
            rd_cmp = 1'b1;
            for (int i = 0; i < device_total; i++) begin
                if (responding[i]) begin
                    rd_id  &= device_rom[i][b];
                    rd_cmp &= ~device_rom[i][b];
                end
            end
            send_item(owrs_pkg::OP_BIT_PAIR, 1'($urandom), rd_id, rd_cmp, 8'($urandom));
            if (b < owrs_pkg::ROM_BITS - 1 && engine_phase != PH_SEARCH)
                return;
            for (int i = 0; i < device_total; i++)
                if (device_rom[i][b] != search_dir)
                    responding[i] = 1'b0;
        end
    endtask

    task automatic enumerate_bus();
        int          shared;
        int          pick;
        logic [63:0] mask;
        device_total = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, MAX_DEVICES);
        for (int i = 0; i < device_total; i++) begin
            device_rom[i] = {$urandom, $urandom};
            if (i > 0 && $urandom_range(1)) begin
                shared = $urandom_range(1, owrs_pkg::ROM_BITS - 1);
                mask = (64'd1 << shared) - 64'd1;
                device_rom[i] = (device_rom[i] & ~mask) | (device_rom[0] & mask);
            end
        end
        if ($urandom_range(19) == 0)
            for (int i = 0; i < device_total; i++)
                device_rom[i][7:0] = 8'd0;
        run_search(owrs_pkg::OP_START_FIRST, $urandom_range(9) == 0);
        for (int n = 0; n < 6; n++) begin
            if (!search_found || at_last_device)
                break;
            if ($urandom_range(9) == 0)
                send_noise();
            pick = $urandom_range(9);
            if (pick == 0)
                send_item(owrs_pkg::OP_TARGET_FAM, 1'($urandom), 1'($urandom), 1'($urandom),
                          $urandom_range(1) ? device_rom[$urandom_range(device_total - 1)][7:0]
                                            : 8'($urandom));
            else if (pick == 1)
                send_item(owrs_pkg::OP_SKIP_FAM, 1'($urandom), 1'($urandom), 1'($urandom),
                          8'($urandom));
            run_search(owrs_pkg::OP_START_NEXT, $urandom_range(9) == 0);
        end
        if (at_last_device && $urandom_range(2) == 0)
            run_search(owrs_pkg::OP_START_NEXT, 1'b0);
    endtask

    task automatic test_ignored_when_idle();
        send_item(owrs_pkg::OP_PRESENCE, 1'b1, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_BIT_PAIR, 1'b0, 1'b0, 1'b1, 8'h00);
        send_item(OP_UNUSED_6, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_item(OP_UNUSED_7, 1'b0, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_family_setup();
        send_item(owrs_pkg::OP_TARGET_FAM, 1'b0, 1'b0, 1'b0, 8'hFF);
        send_item(owrs_pkg::OP_SKIP_FAM, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_START_NEXT, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_TARGET_FAM, 1'b1, 1'b1, 1'b1, 8'h00);
        send_item(owrs_pkg::OP_SKIP_FAM, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_item(owrs_pkg::OP_START_FIRST, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_PRESENCE, 1'b0, 1'b0, 1'b0, 8'h00);
    endtask

    task automatic test_search_interrupts();
        send_item(owrs_pkg::OP_START_FIRST, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_BIT_PAIR, 1'b0, 1'b1, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_PRESENCE, 1'b1, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_TARGET_FAM, 1'b0, 1'b0, 1'b0, 8'hA5);
        send_item(owrs_pkg::OP_SKIP_FAM, 1'b0, 1'b0, 1'b0, 8'h5A);
        send_item(owrs_pkg::OP_PRESENCE, 1'b1, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_BIT_PAIR, 1'b0, 1'b1, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_START_NEXT, 1'b0, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_PRESENCE, 1'b1, 1'b0, 1'b0, 8'h00);
        send_item(owrs_pkg::OP_BIT_PAIR, 1'b0, 1'b1, 1'b1, 8'h00);
    endtask

    task automatic test_random_traffic();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            steady = (items_sent >= 300 && items_sent < 520);
            enumerate_bus();
        end
        steady = 1'b0;
    endtask

    initial begin
        rom_image       = '0;
        clear_discrepancies();
        next_bit        = owrs_pkg::POS_FIRST;
        zero_taken      = '0;
        engine_phase    = PH_IDLE;
        search_dir      = 1'b0;
        search_found    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_when_idle();
        test_family_setup();
        test_search_interrupts();
        test_random_traffic();

        s_valid <= 1'b0;
        while (owed_actions.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && owed_actions.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
